/* design/kplc_pkg.sv */
// ----------------------------------------------------------------------------
// kplc_pkg
// Shared constants, codes and types of the keypad lock controller.
// ----------------------------------------------------------------------------
package kplc_pkg;

    // Password length and the index width that it needs
    localparam int PASS_LEN = 5;
    localparam int IDX_W    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;

    // Output queue depth: room for two results per item plus slack
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIALS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TICKS  = 3'd7;

    // Configuration reset values
    localparam logic [7:0] RST_READY_CODE   = 8'h10;
    localparam logic [7:0] RST_OPEN_CODE    = 8'h2B;
    localparam logic [7:0] RST_CHANGE_CODE  = 8'h2D;
    localparam logic [3:0] RST_MAX_TRIALS   = 4'd3;
    localparam logic [7:0] RST_UNLOCK_TICKS = 8'd5;
    localparam logic [7:0] RST_HOLD_TICKS   = 8'd6;
    localparam logic [7:0] RST_LOCK_TICKS   = 8'd11;
    localparam logic [7:0] RST_ALARM_TICKS  = 8'd20;

    // Input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Motor drive codes
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_CCW  = 2'd2;

    // Reply bytes
    localparam logic [7:0] TX_MATCH    = 8'd1;
    localparam logic [7:0] TX_MISMATCH = 8'd0;

    typedef struct packed {
        logic [7:0] ready_code;
        logic [7:0] open_code;
        logic [7:0] change_code;
        logic [3:0] max_trials;
        logic [7:0] unlock_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] lock_ticks;
        logic [7:0] alarm_ticks;
    } t_cfg;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] motor_drive;
        logic       alarm_on;
        logic       last_result;
    } t_result;

    // Up to two result words written into the output queue at once
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

/* design/kplc_ifs.sv */
// ----------------------------------------------------------------------------
// kplc_ifs
// Valid/ready channels of the keypad lock controller: input items, result
// words and configuration writes.
// ----------------------------------------------------------------------------
interface kplc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, opcode, rx_byte, input ready);
    modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface kplc_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_drive;
    logic       alarm_on;
    logic       last_result;

    modport source (output valid, tx_valid, tx_byte, motor_drive, alarm_on,
                    last_result, input ready);
    modport sink   (input valid, tx_valid, tx_byte, motor_drive, alarm_on,
                    last_result, output ready);
endinterface

interface kplc_cfg_if
    import kplc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/kplc_cfg.sv */
// ----------------------------------------------------------------------------
// kplc_cfg
// Configuration register file: codes, trial limit and tick thresholds.
// ----------------------------------------------------------------------------
module kplc_cfg
    import kplc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    kplc_cfg_if.sink       i_cfg,
    output t_cfg           o_cfg
);

    t_cfg r_cfg;

    // Always take a write word
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_code   <= RST_READY_CODE;
            r_cfg.open_code    <= RST_OPEN_CODE;
            r_cfg.change_code  <= RST_CHANGE_CODE;
            r_cfg.max_trials   <= RST_MAX_TRIALS;
            r_cfg.unlock_ticks <= RST_UNLOCK_TICKS;
            r_cfg.hold_ticks   <= RST_HOLD_TICKS;
            r_cfg.lock_ticks   <= RST_LOCK_TICKS;
            r_cfg.alarm_ticks  <= RST_ALARM_TICKS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_READY_CODE:   r_cfg.ready_code   <= i_cfg.data;
                CFG_OPEN_CODE:    r_cfg.open_code    <= i_cfg.data;
                CFG_CHANGE_CODE:  r_cfg.change_code  <= i_cfg.data;
                CFG_MAX_TRIALS:   r_cfg.max_trials   <= i_cfg.data[3:0];
                CFG_UNLOCK_TICKS: r_cfg.unlock_ticks <= i_cfg.data;
                CFG_HOLD_TICKS:   r_cfg.hold_ticks   <= i_cfg.data;
                CFG_LOCK_TICKS:   r_cfg.lock_ticks   <= i_cfg.data;
                CFG_ALARM_TICKS:  r_cfg.alarm_ticks  <= i_cfg.data;
            endcase
        end
    end

endmodule

/* design/kplc_fsm.sv */
// ----------------------------------------------------------------------------
// kplc_fsm
// Input register and session state machine. One registered item is
// processed per cycle whenever the output queue has room for two words.
// ----------------------------------------------------------------------------
module kplc_fsm
    import kplc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    kplc_item_if.sink      i_item,
    input  t_cfg           i_cfg,
    input  logic           i_room,
    output t_push          o_push
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SET1,
        PH_SET2,
        PH_MENU,
        PH_VERIFY,
        PH_MOTOR,
        PH_ALARM
    } t_phase;

    typedef enum logic [1:0] {
        STG_CW,
        STG_STOP,
        STG_CCW,
        STG_DONE
    } t_stage;

    // Motor stage for a tick count; later thresholds never fall below earlier
    function automatic t_stage motor_stage(input logic [7:0] tick, input t_cfg c);
        logic [7:0] e2;
        logic [7:0] e3;
        t_stage     s;
        e2 = (c.hold_ticks > c.unlock_ticks) ? c.hold_ticks : c.unlock_ticks;
        e3 = (c.lock_ticks > e2) ? c.lock_ticks : e2;
        if (tick < c.unlock_ticks) begin
            s = STG_CW;
        end else if (tick < e2) begin
            s = STG_STOP;
        end else if (tick < e3) begin
            s = STG_CCW;
        end else begin
            s = STG_DONE;
        end
        return s;
    endfunction

    // Input register
    logic             r_in_valid;
    logic [1:0]       r_in_op;
    logic [7:0]       r_in_byte;

    // Session state
    t_phase           r_phase,    n_phase;
    logic [IDX_W-1:0] r_idx,      n_idx;
    logic             r_mismatch, n_mismatch;
    logic [3:0]       r_trial,    n_trial;
    logic             r_open,     n_open;
    logic [7:0]       r_tick,     n_tick;
    logic [7:0]       r_first  [PASS_LEN];
    logic [7:0]       r_stored [PASS_LEN];

    logic             step;
    logic [IDX_W-1:0] idx;
    logic             last_byte;
    logic [7:0]       tick_inc;
    logic             wr_first;
    logic             copy_stored;
    logic             mis_set2;
    logic             mis_verify;
    logic [1:0]       ntx;
    logic [7:0]       tx0;
    logic [7:0]       tx1;
    logic [1:0]       drive;
    logic             buzz;

    assign step         = r_in_valid && i_room;
    assign i_item.ready = !r_in_valid || step;

    // Clamp a stray index to the first byte
    assign idx        = (32'(r_idx) >= PASS_LEN) ? '0 : r_idx;
    assign last_byte  = (idx == IDX_W'(PASS_LEN - 1));
    assign tick_inc   = (r_tick == 8'hFF) ? r_tick : r_tick + 8'd1;
    assign mis_set2   = r_mismatch || (r_first[idx] != r_in_byte);
    assign mis_verify = r_mismatch || (r_stored[idx] != r_in_byte);

    // Work out the next state and the replies for the held item
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_mismatch  = r_mismatch;
        n_trial     = r_trial;
        n_open      = r_open;
        n_tick      = r_tick;
        wr_first    = 1'b0;
        copy_stored = 1'b0;
        ntx         = 2'd0;
        tx0         = TX_MISMATCH;
        tx1         = TX_MISMATCH;

        unique case (r_in_op)
            OP_TICK: begin
                if (r_phase == PH_MOTOR) begin
                    n_tick = tick_inc;
                    if (motor_stage(tick_inc, i_cfg) == STG_DONE) begin
                        n_phase = PH_MENU;
                    end
                end else if (r_phase == PH_ALARM) begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.alarm_ticks) begin
                        n_phase = PH_MENU;
                    end
                end
            end
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase    = PH_SET1;
                    n_idx      = '0;
                    n_mismatch = 1'b0;
                    ntx        = 2'd1;
                    tx0        = i_cfg.ready_code;
                end
            end
            OP_BYTE: begin
                unique case (r_phase)
                    PH_SET1: begin
                        wr_first = 1'b1;
                        if (last_byte) begin
                            n_phase    = PH_SET2;
                            n_idx      = '0;
                            n_mismatch = 1'b0;
                            ntx        = 2'd1;
                            tx0        = i_cfg.ready_code;
                        end else begin
                            n_idx = IDX_W'(idx + 1'b1);
                        end
                    end
                    PH_SET2: begin
                        if (last_byte) begin
                            n_idx = '0;
                            if (!mis_set2) begin
                                copy_stored = 1'b1;
                                n_mismatch  = 1'b0;
                                ntx         = 2'd1;
                                tx0         = TX_MATCH;
                                n_phase     = PH_MENU;
                            end else begin
                                n_mismatch = 1'b0;
                                ntx        = 2'd2;
                                tx0        = TX_MISMATCH;
                                tx1        = i_cfg.ready_code;
                                n_phase    = PH_SET1;
                            end
                        end else begin
                            n_idx      = IDX_W'(idx + 1'b1);
                            n_mismatch = mis_set2;
                        end
                    end
                    PH_MENU: begin
                        if (r_in_byte == i_cfg.open_code ||
                            r_in_byte == i_cfg.change_code) begin
                            n_open     = (r_in_byte == i_cfg.open_code);
                            n_trial    = 4'd1;
                            n_phase    = PH_VERIFY;
                            n_idx      = '0;
                            n_mismatch = 1'b0;
                            ntx        = 2'd1;
                            tx0        = i_cfg.ready_code;
                        end
                    end
                    PH_VERIFY: begin
                        if (last_byte) begin
                            n_idx = '0;
                            if (!mis_verify) begin
                                n_mismatch = 1'b0;
                                n_trial    = 4'd1;
                                tx0        = TX_MATCH;
                                if (r_open) begin
                                    ntx    = 2'd1;
                                    n_tick = 8'd0;
                                    if (motor_stage(8'd0, i_cfg) == STG_DONE) begin
                                        n_phase = PH_MENU;
                                    end else begin
                                        n_phase = PH_MOTOR;
                                    end
                                end else begin
                                    ntx     = 2'd2;
                                    tx1     = i_cfg.ready_code;
                                    n_phase = PH_SET1;
                                end
                            end else begin
                                tx0 = TX_MISMATCH;
                                if (r_trial >= i_cfg.max_trials) begin
                                    n_mismatch = 1'b1;
                                    ntx        = 2'd1;
                                    n_tick     = 8'd0;
                                    if (i_cfg.alarm_ticks == 8'd0) begin
                                        n_phase = PH_MENU;
                                    end else begin
                                        n_phase = PH_ALARM;
                                    end
                                end else begin
                                    n_trial    = r_trial + 4'd1;
                                    n_mismatch = 1'b0;
                                    ntx        = 2'd2;
                                    tx1        = i_cfg.ready_code;
                                end
                            end
                        end else begin
                            n_idx      = IDX_W'(idx + 1'b1);
                            n_mismatch = mis_verify;
                        end
                    end
                    default: begin
                        // drop bytes while idle, running the motor or sounding the alarm
                    end
                endcase
            end
            default: begin
                // drop unused opcodes
            end
        endcase
    end

    // Status after the item
    always_comb begin
        drive = MOTOR_STOP;
        if (n_phase == PH_MOTOR) begin
            unique case (motor_stage(n_tick, i_cfg))
                STG_CW:  drive = MOTOR_CW;
                STG_CCW: drive = MOTOR_CCW;
                default: drive = MOTOR_STOP;
            endcase
        end
    end
    assign buzz = (n_phase == PH_ALARM);

    // Build the result words for the output queue
    always_comb begin
        o_push.count              = step ? ((ntx == 2'd0) ? 2'd1 : ntx) : 2'd0;
        o_push.first.tx_valid     = (ntx != 2'd0);
        o_push.first.tx_byte      = (ntx != 2'd0) ? tx0 : 8'd0;
        o_push.first.motor_drive  = drive;
        o_push.first.alarm_on     = buzz;
        o_push.first.last_result  = (ntx != 2'd2);
        o_push.second.tx_valid    = 1'b1;
        o_push.second.tx_byte     = tx1;
        o_push.second.motor_drive = drive;
        o_push.second.alarm_on    = buzz;
        o_push.second.last_result = 1'b1;
    end

    // Hold the input word and the session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_idx      <= '0;
            r_mismatch <= 1'b0;
            r_trial    <= 4'd1;
            r_open     <= 1'b0;
            r_tick     <= 8'd0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (step) begin
                r_phase    <= n_phase;
                r_idx      <= n_idx;
                r_mismatch <= n_mismatch;
                r_trial    <= n_trial;
                r_open     <= n_open;
                r_tick     <= n_tick;
            end
        end
    end

    // Input payload and password stores need no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op   <= i_item.opcode;
            r_in_byte <= i_item.rx_byte;
        end
        if (step && wr_first) begin
            r_first[idx] <= r_in_byte;
        end
        if (step && copy_stored) begin
            for (int k = 0; k < PASS_LEN; k++) begin
                r_stored[k] <= r_first[k];
            end
        end
    end

endmodule

/* design/kplc_oq.sv */
// ----------------------------------------------------------------------------
// kplc_oq
// Output queue: takes one or two result words per cycle, gives one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module kplc_oq
    import kplc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_push          i_push,
    output logic           o_room,
    kplc_result_if.source  o_result
);

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;
    logic [OQ_PTR_W-1:0] wr_ptr_nx;
    t_result             head;

    assign pop       = o_result.valid && o_result.ready;
    assign o_room    = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign wr_ptr_nx = r_wr_ptr + 1'b1;
    assign head      = r_mem[r_rd_ptr];

    // Present the head word
    assign o_result.valid       = (r_count != '0);
    assign o_result.tx_valid    = head.tx_valid;
    assign o_result.tx_byte     = head.tx_byte;
    assign o_result.motor_drive = head.motor_drive;
    assign o_result.alarm_on    = head.alarm_on;
    assign o_result.last_result = head.last_result;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(pop);
            r_count  <= r_count + OQ_CNT_W'(i_push.count) - OQ_CNT_W'(pop);
        end
    end

    // Write the incoming words
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_nx] <= i_push.second;
        end
    end

endmodule

/* design/keypad_lock_controller_core.sv */
// ----------------------------------------------------------------------------
// keypad_lock_controller_core
// Password door lock controller: setup, menu, verification, motor cycle and
// alarm, driven by link bytes, timer ticks and a start word.
// ----------------------------------------------------------------------------
// Order: the input word is held in the input register; its result words are
//          then written into the output queue, whose head drives the output.
// Throughput: one input word per cycle while the queue has room for two words;
//          the single output port gives one result word per cycle when ready.
// Reset: synchronous, active low; clears the session state and loads the
//          default configuration; password stores hold no reset value.
// ----------------------------------------------------------------------------
module keypad_lock_controller_core
    import kplc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    kplc_item_if.sink      i_item,
    kplc_result_if.source  o_result,
    kplc_cfg_if.sink       i_cfg
);

    t_cfg  cfg;
    t_push push;
    logic  room;

    kplc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    kplc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    kplc_oq u_oq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule
